// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

  // Defaults for the top-level parameters
  localparam int RING_DEPTH_DEF = 64;
  localparam int TIME_WIDTH_DEF = 32;

  // Protocol constants
  localparam int RETRY_LIMIT    = 5;
  localparam int WARMUP_PACKETS = 10;
  localparam int US_PER_MS      = 1000;
  // Warm-up timeout: elapsed/1000 > 100  <=>  elapsed >= 101 * 1000
  localparam int WARMUP_THRESH  = (100 + 1) * US_PER_MS;

  // Shared divider geometry: numerator covers mean*samples + elapsed
  localparam int NUM_W = 49;
  localparam int DEN_W = 17;
  // Quotient of 2*mean/1000 and the threshold built from it
  localparam int Q_W   = 24;
  localparam int THR_W = 35;

  // Operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_GEN  = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;
  localparam logic [1:0] OP_SEND = 2'd3;

  // Register map
  localparam int          ADDR_W      = 4;
  localparam logic [3:0]  ADDR_WINDOW = 4'h0;
  localparam logic [3:0]  ADDR_TOTAL  = 4'h4;
  localparam logic [3:0]  ADDR_LIMIT  = 4'h8;

  localparam logic [6:0]  WINDOW_RST = 7'd8;
  localparam logic [15:0] TOTAL_RST  = 16'd1000;
  localparam logic [15:0] LIMIT_RST  = 16'd64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] ack_seq;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_seq;
    logic [7:0]  send_header;
    logic        timed_out;
    logic        done_res;
    logic        failed;
    logic [31:0] rtt_average;
    logic [15:0] base_seq;
    logic [31:0] sent_total;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/gbn_div.sv =====
module gbn_div #(
  parameter int NUM_W = gbn_pkg::NUM_W,
  parameter int DEN_W = gbn_pkg::DEN_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output gbn_pkg::div_sts_t     sts,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Shift in the next numerator bit and try the subtract
  assign rem_sh = {rem, quot[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // One quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        rem   <= '0;
        quot  <= num;
        den_r <= den;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== rtl/go_back_n_sender.sv =====
// Channel   Direction  Payload            Handshake
// item      in         gbn_pkg::item_t    item_valid / item_stall
// result    out        gbn_pkg::result_t  result_valid / result_stall
// config    in         window/total/limit APB psel/penable/pwrite, pready high
//
// Ack: two passes of the shared bit-serial divider, the mean update and then
// the threshold quotient.
// After reset a clearing pass zeroes every entry of the retry-count ring;
// items are stalled meanwhile, configuration writes are taken.
// A new item is taken while a finished result waits; the item completes
// only once the result register is free.
module go_back_n_sender #(
  parameter int RING_DEPTH = gbn_pkg::RING_DEPTH_DEF,
  parameter int TIME_WIDTH = gbn_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  gbn_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output gbn_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbn_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CMP_W = (TIME_WIDTH > gbn_pkg::THR_W) ? TIME_WIDTH : gbn_pkg::THR_W;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_TICK_RD   = 4'd2;
  localparam logic [3:0] S_TICK_CMP  = 4'd3;
  localparam logic [3:0] S_ACK_RD    = 4'd4;
  localparam logic [3:0] S_ACK_SUM   = 4'd5;
  localparam logic [3:0] S_ACK_DIV   = 4'd6;
  localparam logic [3:0] S_THR_START = 4'd7;
  localparam logic [3:0] S_THR_DIV   = 4'd8;
  localparam logic [3:0] S_THR_MUL   = 4'd9;
  localparam logic [3:0] S_SEND_RD   = 4'd10;
  localparam logic [3:0] S_SEND_CHK  = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0]            state;
  logic [IDX_W-1:0]      clr_addr;

  logic [6:0]            win_limit;
  logic [15:0]           total_packets;
  logic [15:0]           buffer_limit;

  logic [15:0]           base;
  logic [15:0]           next_to_send;
  logic [IDX_W-1:0]      base_slot;
  logic [IDX_W-1:0]      next_slot;
  logic [15:0]           generated_count;
  logic [15:0]           buffered_count;
  logic                  timeout_flag;
  logic                  fail_flag;
  logic [TIME_WIDTH-1:0] clock_us;
  logic [31:0]           mean_rtt;
  logic [15:0]           rtt_samples;
  logic [31:0]           transmissions;
  logic [gbn_pkg::THR_W-1:0] thresh;
  logic [gbn_pkg::Q_W-1:0]   thr_q;
  logic [47:0]           prod;
  logic                  send_flag;
  logic [15:0]           send_seq_r;

  logic [TIME_WIDTH-1:0] time_mem [RING_DEPTH];
  logic [2:0]            cnt_mem  [RING_DEPTH];
  logic [TIME_WIDTH-1:0] time_rd;
  logic [2:0]            cnt_rd;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_wa;
  logic [2:0]            cnt_wd;
  logic                  time_we;

  logic                  accept;
  logic                  halted;
  logic                  out_free;
  logic                  cfg_we;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [15:0]           next_eff;
  logic [IDX_W-1:0]      slot_eff;
  logic [15:0]           diff;
  logic                  blocked;
  logic [CMP_W-1:0]      limit_us;
  logic                  retry_over;

  logic                        div_start;
  logic [gbn_pkg::NUM_W-1:0]   div_num;
  logic [gbn_pkg::DEN_W-1:0]   div_den;
  gbn_pkg::div_sts_t           div_sts;
  logic [gbn_pkg::NUM_W-1:0]   div_quot;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign halted     = fail_flag || (base >= total_packets);
  assign out_free   = !result_valid || !result_stall;
  assign elapsed    = clock_us - time_rd;
  assign retry_over = cnt_rd > 3'(gbn_pkg::RETRY_LIMIT);

  // Send eligibility, after a pending timeout rewinds to base
  assign next_eff = timeout_flag ? base : next_to_send;
  assign slot_eff = timeout_flag ? base_slot : next_slot;
  assign diff     = next_eff - base;
  assign blocked  = (17'(diff) >= 17'(win_limit)) || (17'(diff) >= 17'(RING_DEPTH)) ||
                    (next_eff >= generated_count) || (next_eff >= total_packets);

  // Timeout threshold in microseconds
  assign limit_us = (base < 16'(gbn_pkg::WARMUP_PACKETS)) ?
                    CMP_W'(gbn_pkg::WARMUP_THRESH) : CMP_W'(thresh);

  // Shared divider operands: mean update, then 2*mean/1000
  assign div_start = (state == S_ACK_SUM) || (state == S_THR_START);
  always_comb begin
    if (state == S_ACK_SUM) begin
      div_num = gbn_pkg::NUM_W'(prod) + gbn_pkg::NUM_W'(elapsed);
      div_den = gbn_pkg::DEN_W'(rtt_samples) + 1'b1;
    end else begin
      div_num = gbn_pkg::NUM_W'({mean_rtt, 1'b0});
      div_den = gbn_pkg::DEN_W'(gbn_pkg::US_PER_MS);
    end
  end

  gbn_div #(
    .NUM_W(gbn_pkg::NUM_W),
    .DEN_W(gbn_pkg::DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .sts  (div_sts),
    .quot (div_quot)
  );

  // Retry-count ring write port: clear sweep, ack release, send increment
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = next_slot;
    cnt_wd = '0;
    if (state == S_CLEAR) begin
      cnt_we = 1'b1;
      cnt_wa = clr_addr;
    end else if (state == S_ACK_DIV && div_sts.done) begin
      cnt_we = 1'b1;
      cnt_wa = base_slot;
    end else if (state == S_SEND_CHK && !retry_over) begin
      cnt_we = 1'b1;
      cnt_wd = cnt_rd + 1'b1;
    end
  end
  assign time_we = (state == S_SEND_CHK) && !retry_over;

  // Rings, read data registered
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (time_we) begin
      time_mem[next_slot] <= clock_us;
    end
    cnt_rd  <= cnt_mem[next_slot];
    time_rd <= time_mem[base_slot];
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      win_limit     <= gbn_pkg::WINDOW_RST;
      total_packets <= gbn_pkg::TOTAL_RST;
      buffer_limit  <= gbn_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (paddr)
        gbn_pkg::ADDR_WINDOW: win_limit     <= pwdata[6:0];
        gbn_pkg::ADDR_TOTAL:  total_packets <= pwdata[15:0];
        gbn_pkg::ADDR_LIMIT:  buffer_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      gbn_pkg::ADDR_WINDOW: prdata = 32'(win_limit);
      gbn_pkg::ADDR_TOTAL:  prdata = 32'(total_packets);
      gbn_pkg::ADDR_LIMIT:  prdata = 32'(buffer_limit);
      default:              prdata = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      base            <= '0;
      next_to_send    <= '0;
      base_slot       <= '0;
      next_slot       <= '0;
      generated_count <= '0;
      buffered_count  <= '0;
      timeout_flag    <= 1'b0;
      fail_flag       <= 1'b0;
      clock_us        <= '0;
      mean_rtt        <= '0;
      rtt_samples     <= '0;
      transmissions   <= '0;
      thresh          <= gbn_pkg::THR_W'(gbn_pkg::US_PER_MS);
      send_flag       <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      // Raise the result on completion, drop it once taken
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(RING_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            send_flag <= 1'b0;
            state     <= S_DONE;
            if (!halted) begin
              case (item.operation)
                gbn_pkg::OP_TICK: begin
                  clock_us <= clock_us + 1'b1;
                  if (!timeout_flag && base != next_to_send) begin
                    state <= S_TICK_RD;
                  end
                end
                gbn_pkg::OP_GEN: begin
                  if (buffered_count < buffer_limit) begin
                    buffered_count <= buffered_count + 1'b1;
                    if (generated_count != 16'hFFFF) begin
                      generated_count <= generated_count + 1'b1;
                    end
                  end
                end
                gbn_pkg::OP_ACK: begin
                  if (item.ack_seq == base && base != next_to_send) begin
                    state <= S_ACK_RD;
                  end
                end
                gbn_pkg::OP_SEND: begin
                  next_to_send <= next_eff;
                  next_slot    <= slot_eff;
                  if (!blocked) begin
                    state <= S_SEND_RD;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_TICK_RD: begin
          state <= S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (CMP_W'(elapsed) >= limit_us) begin
            timeout_flag <= 1'b1;
          end
          state <= S_DONE;
        end
        S_ACK_RD: begin
          state <= S_ACK_SUM;
        end
        S_ACK_SUM: begin
          state <= S_ACK_DIV;
        end
        S_ACK_DIV: begin
          if (div_sts.done) begin
            mean_rtt <= (div_quot[gbn_pkg::NUM_W-1:32] != '0) ? '1 : div_quot[31:0];
            if (rtt_samples != 16'hFFFF) begin
              rtt_samples <= rtt_samples + 1'b1;
            end
            base      <= base + 1'b1;
            base_slot <= (base_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : base_slot + 1'b1;
            if (buffered_count != '0) begin
              buffered_count <= buffered_count - 1'b1;
            end
            state <= S_THR_START;
          end
        end
        S_THR_START: begin
          state <= S_THR_DIV;
        end
        S_THR_DIV: begin
          if (div_sts.done) begin
            thr_q <= div_quot[gbn_pkg::Q_W-1:0];
            state <= S_THR_MUL;
          end
        end
        S_THR_MUL: begin
          thresh <= (gbn_pkg::THR_W'(thr_q) + 1'b1) *
                    gbn_pkg::THR_W'(gbn_pkg::US_PER_MS);
          state  <= S_DONE;
        end
        S_SEND_RD: begin
          state <= S_SEND_CHK;
        end
        S_SEND_CHK: begin
          if (retry_over) begin
            fail_flag <= 1'b1;
          end else begin
            if (transmissions != '1) begin
              transmissions <= transmissions + 1'b1;
            end
            send_flag    <= 1'b1;
            send_seq_r   <= next_to_send;
            next_to_send <= next_to_send + 1'b1;
            next_slot    <= (next_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : next_slot + 1'b1;
            if (timeout_flag && base == next_to_send) begin
              timeout_flag <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the finished transaction for the consumer
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.send_valid  <= send_flag;
      result.send_seq    <= send_flag ? send_seq_r : '0;
      result.send_header <= send_flag ? send_seq_r[7:0] : '0;
      result.timed_out   <= timeout_flag;
      result.done_res    <= base >= total_packets;
      result.failed      <= fail_flag;
      result.rtt_average <= mean_rtt;
      result.base_seq    <= base;
      result.sent_total  <= transmissions;
    end
  end

  // Product for the running mean
  always_ff @(posedge clk) begin
    if (state == S_ACK_RD) begin
      prod <= mean_rtt * rtt_samples;
    end
  end

`ifndef ASSERT_OFF
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    fail_flag |=> fail_flag)
    else $error("fail flag dropped");

  a_base_order: assert property (@(posedge clk) disable iff (rst)
    base <= next_to_send)
    else $error("base passed next_to_send");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_div_use: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_ACK_DIV || state == S_THR_DIV))
    else $error("divider finished with no consumer");
`endif

endmodule

// ===== verif/go_back_n_sender_test.sv =====
module go_back_n_sender_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_WAIT = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  gbn_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  gbn_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gbn_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;

  // Scoreboard: mirrors sender state and queues the expected outcome per transaction
  class gbn_scoreboard;
    bit [6:0]  window;
    bit [15:0] total, limit;
    bit [15:0] base, next_seq, gen_cnt, buf_cnt;
    bit        tmo, fail;
    bit [31:0] clock_us;
    bit [31:0] sent_at [RING];
    bit [2:0]  tries [RING];
    bit [31:0] mean, tx_count;
    bit [15:0] samples;
    gbn_pkg::result_t pending [$];
    int        errors;

    function new();
      window = gbn_pkg::WINDOW_RST;
      total = gbn_pkg::TOTAL_RST;
      limit = gbn_pkg::LIMIT_RST;
      for (int i = 0; i < RING; i++) begin
        sent_at[i] = '0;
        tries[i] = '0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [gbn_pkg::ADDR_W-1:0] addr, logic [31:0] data);
      case (addr)
        gbn_pkg::ADDR_WINDOW: window = data[6:0];
        gbn_pkg::ADDR_TOTAL:  total = data[15:0];
        gbn_pkg::ADDR_LIMIT:  limit = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_item(gbn_pkg::item_t it);
      gbn_pkg::result_t exp;
      longint unsigned elapsed, lim, m;
      int unsigned win, slot;
      bit [31:0] dt;
      exp = '0;
      if (!fail && base < total) begin
        case (it.operation)
          gbn_pkg::OP_TICK: begin
            clock_us++;
            if (!tmo && base != next_seq) begin
              dt = clock_us - sent_at[base % RING];
              elapsed = dt;
              lim = (base < gbn_pkg::WARMUP_PACKETS) ? 64'd100
                    : (64'(mean) * 2) / gbn_pkg::US_PER_MS;
              if (elapsed / gbn_pkg::US_PER_MS > lim) tmo = 1'b1;
            end
          end
          gbn_pkg::OP_GEN: begin
            if (buf_cnt < limit) begin
              if (gen_cnt != 16'hFFFF) gen_cnt++;
              buf_cnt++;
            end
          end
          gbn_pkg::OP_ACK: begin
            if (it.ack_seq == base && base != next_seq) begin
              dt = clock_us - sent_at[base % RING];
              elapsed = dt;
              m = (64'(mean) * samples + elapsed) / (64'(samples) + 1);
              mean = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
              if (samples != 16'hFFFF) samples++;
              tries[base % RING] = '0;
              base++;
              if (buf_cnt > 0) buf_cnt--;
            end
          end
          default: begin
            win = (window < RING) ? window : RING;
            if (tmo) next_seq = base;
            if (!(int'(next_seq) - int'(base) >= win || next_seq >= gen_cnt
                  || next_seq >= total)) begin
              slot = next_seq % RING;
              if (tries[slot] > gbn_pkg::RETRY_LIMIT) begin
                fail = 1'b1;
              end else begin
                if (tries[slot] < 7) tries[slot]++;
                if (tx_count != 32'hFFFF_FFFF) tx_count++;
                sent_at[slot] = clock_us;
                exp.send_valid = 1'b1;
                exp.send_seq = next_seq;
                exp.send_header = next_seq[7:0];
                next_seq++;
                if (tmo && base == next_seq - 1) tmo = 1'b0;
              end
            end
          end
        endcase
      end
      exp.timed_out = tmo;
      exp.done_res = (base >= total);
      exp.failed = fail;
      exp.rtt_average = mean;
      exp.base_seq = base;
      exp.sent_total = tx_count;
      pending.insert(pending.size(), exp);
    endfunction

    task compare(string name, longint unsigned got, longint unsigned want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(gbn_pkg::result_t got);
      gbn_pkg::result_t exp;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp = pending.pop_front();
      compare("send_valid", got.send_valid, exp.send_valid);
      compare("send_seq", got.send_seq, exp.send_seq);
      compare("send_header", got.send_header, exp.send_header);
      compare("timed_out", got.timed_out, exp.timed_out);
      compare("done_res", got.done_res, exp.done_res);
      compare("failed", got.failed, exp.failed);
      compare("rtt_average", got.rtt_average, exp.rtt_average);
      compare("base_seq", got.base_seq, exp.base_seq);
      compare("sent_total", got.sent_total, exp.sent_total);
    endtask
  endclass

  gbn_scoreboard sb = new();

  go_back_n_sender uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_back_n_sender_test: FAIL");
      $finish;
    end
  end

  function int draw_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Offer one transaction after a gap, hold it until taken
  task automatic push_item(logic [1:0] op, logic [15:0] seq, int gap);
    gbn_pkg::item_t it;
    it.operation = op;
    it.ack_seq = seq;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic push(logic [1:0] op, logic [15:0] seq = '0);
    push_item(op, seq, draw_gap());
  endtask

  // Hold off until the block has gone quiet
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write a register through setup and access, then read it back
  task automatic apb_write(logic [gbn_pkg::ADDR_W-1:0] addr, logic [31:0] data);
    logic [31:0] mask;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mask = (addr == gbn_pkg::ADDR_WINDOW) ? 32'h7F : 32'hFFFF;
    if ((prdata & mask) != (data & mask))
      sb.report($sformatf("register %0h read %0h expected %0h", addr, prdata, data & mask));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int win, int tot, int lim);
    drain();
    apb_write(gbn_pkg::ADDR_WINDOW, win);
    apb_write(gbn_pkg::ADDR_TOTAL, tot);
    apb_write(gbn_pkg::ADDR_LIMIT, lim);
  endtask

  // One random transaction, mostly well-formed
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) push(gbn_pkg::OP_TICK, 16'($urandom));
    else if (r < 40) push(gbn_pkg::OP_GEN, 16'($urandom));
    else if (r < 70) push(gbn_pkg::OP_SEND, 16'($urandom));
    else if (r < 92) push(gbn_pkg::OP_ACK, sb.base);
    else push(gbn_pkg::OP_ACK, 16'($urandom));
  endtask

  // Receiver: random stalls, with one long hold-off on request
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: basic flow, stray acks, empty send
    push(gbn_pkg::OP_GEN); push(gbn_pkg::OP_GEN);
    push(gbn_pkg::OP_SEND); push(gbn_pkg::OP_SEND);
    push(gbn_pkg::OP_ACK, 16'd1); push(gbn_pkg::OP_ACK, 16'd0);
    push(gbn_pkg::OP_ACK, 16'd0);
    push(gbn_pkg::OP_ACK, 16'd1); push(gbn_pkg::OP_ACK, 16'd2);
    push(gbn_pkg::OP_SEND);
    push(gbn_pkg::OP_TICK, 16'hFFFF); push(gbn_pkg::OP_ACK, 16'hFFFF);
    // Zero window never sends
    configure(0, 1000, 64);
    push(gbn_pkg::OP_GEN); push(gbn_pkg::OP_SEND);
    // Single window, buffer of one: extra generation dropped
    configure(1, 1000, 1);
    push(gbn_pkg::OP_SEND); push(gbn_pkg::OP_GEN);
    push(gbn_pkg::OP_SEND); push(gbn_pkg::OP_SEND);
    push(gbn_pkg::OP_ACK, sb.base); push(gbn_pkg::OP_ACK, sb.base);
    // Smallest total: already done, events ignored
    configure(1, 1, 1);
    push(gbn_pkg::OP_GEN); push(gbn_pkg::OP_SEND);
    push(gbn_pkg::OP_TICK); push(gbn_pkg::OP_ACK, sb.base);

    // Random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure(127, 65535, 65535);
        1: configure(64, 65535, 64);
        2: configure(1, 65535, 1);
        default: configure($urandom_range(2, 63), 65535, $urandom_range(2, 100));
      endcase
      if (ph == 1) begin
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (60) random_item();
        calm = 1'b0;
      end
      if (ph == 3) begin
        repeat (40) random_item();
        drain();
      end
      repeat (230) random_item();
    end

    // Done reached mid-run, then released
    configure(8, int'(sb.base), 64);
    push(gbn_pkg::OP_GEN); push(gbn_pkg::OP_SEND);

    configure(1, 65535, 65535);
    push(gbn_pkg::OP_GEN); push(gbn_pkg::OP_SEND);
    push(gbn_pkg::OP_ACK, sb.base); push(gbn_pkg::OP_TICK);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("go_back_n_sender_test: PASS");
    end else begin
      $display("go_back_n_sender_test: FAIL");
    end
    $finish;
  end

endmodule
